### hdl/xor_checked_frame_parser_assert.svh
// Assertion macros shared by the frame parser modules.
`ifndef XOR_CHECKED_FRAME_PARSER_ASSERT_SVH
`define XOR_CHECKED_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication.
`define XCFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define XCFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/xcfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xcfp_pkg;

	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [POS_W:0] MIN_FRAME_LEN = 18'd6;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_HDR   = 3'd2;
	localparam logic [2:0] ST_BAD_SUM   = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	localparam logic REPORT_PAYLOAD = 1'b0;
	localparam logic REPORT_FRAME   = 1'b1;

	localparam logic REG_HDR_FIRST  = 1'b0;
	localparam logic REG_HDR_SECOND = 1'b1;

	typedef struct packed {
		logic [15:0] return_code;
		logic [15:0] payload_length;
		logic [7:0]  subcommand;
		logic [7:0]  command;
		logic [2:0]  frame_status;
		logic [15:0] payload_index;
		logic [7:0]  payload_byte;
		logic        report_kind;
	} xcfp_result_t;

endpackage

`default_nettype wire

### hdl/xcfp_frame_track.sv
`timescale 1ns / 1ps
`default_nettype none

module xcfp_frame_track
	import xcfp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         take,
	input  wire logic [7:0]   in_byte,
	input  wire logic         in_last,
	input  wire logic [7:0]   hdr_first,
	input  wire logic [7:0]   hdr_second,
	output      logic         res_valid,
	output      xcfp_result_t res
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       xor_q;
	logic             hdr_err_q;
	logic [7:0]       cmd_q;
	logic [7:0]       sub_q;
	logic [15:0]      len_q;
	logic [7:0]       code_hi_q;
	logic [7:0]       code_lo_q;

	logic [POS_W-1:0] len_ext;
	logic [POS_W:0]   total;
	logic             in_payload;
	logic [POS_W-1:0] pos_nxt;
	logic [POS_W-1:0] pay_off;

	always_comb begin
		len_ext    = {1'b0, len_q};
		total      = {1'b0, pos_q} + 18'd1;
		in_payload = (pos_q >= 17'd6) && (pos_q < len_ext + 17'd6);
		pos_nxt    = (pos_q != POS_MAX) ? pos_q + 17'd1 : pos_q;
		pay_off    = pos_q - 17'd6;
	end

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (in_last) begin
			res_valid          = take;
			res.report_kind    = REPORT_FRAME;
			res.command        = cmd_q;
			res.subcommand     = sub_q;
			res.payload_length = len_q;
			res.return_code    = {code_hi_q, code_lo_q};
			if (total < MIN_FRAME_LEN) begin
				res.frame_status = ST_SHORT;
			end else if (hdr_err_q) begin
				res.frame_status = ST_BAD_HDR;
			end else if (pos_q < len_ext + 17'd8) begin
				res.frame_status = ST_TRUNCATED;
			end else if (xor_q != in_byte) begin
				res.frame_status = ST_BAD_SUM;
			end else begin
				res.frame_status = ST_OK;
			end
		end else if (in_payload) begin
			res_valid         = take;
			res.report_kind   = REPORT_PAYLOAD;
			res.payload_byte  = in_byte;
			res.payload_index = pay_off[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			xor_q     <= '0;
			hdr_err_q <= 1'b0;
			cmd_q     <= '0;
			sub_q     <= '0;
			len_q     <= '0;
			code_hi_q <= '0;
			code_lo_q <= '0;
		end else if (take) begin
			if (in_last) begin
				pos_q     <= '0;
				xor_q     <= '0;
				hdr_err_q <= 1'b0;
				cmd_q     <= '0;
				sub_q     <= '0;
				len_q     <= '0;
				code_hi_q <= '0;
				code_lo_q <= '0;
			end else begin
				pos_q <= pos_nxt;
				xor_q <= xor_q ^ in_byte;
				if (pos_q == 17'd0) begin
					if (in_byte != hdr_first) hdr_err_q <= 1'b1;
				end else if (pos_q == 17'd1) begin
					if (in_byte != hdr_second) hdr_err_q <= 1'b1;
				end else if (pos_q == 17'd2) begin
					cmd_q <= in_byte;
				end else if (pos_q == 17'd3) begin
					sub_q <= in_byte;
				end else if (pos_q == 17'd4) begin
					len_q[7:0] <= in_byte;
				end else if (pos_q == 17'd5) begin
					len_q[15:8] <= in_byte;
				end else if (pos_q == len_ext + 17'd6) begin
					code_hi_q <= in_byte;
				end else if (pos_q == len_ext + 17'd7) begin
					code_lo_q <= in_byte;
				end
			end
		end
	end

`include "xor_checked_frame_parser_assert.svh"

	`XCFP_ASSERT_NXT(a_clear_after_last, clk, arst_n, take && in_last, pos_q == '0 && xor_q == '0 && !hdr_err_q, "frame state not cleared after final byte")
	`XCFP_ASSERT_NXT(a_pos_advance, clk, arst_n, take && !in_last && pos_q != POS_MAX, pos_q == $past(pos_q) + 17'd1, "byte position did not advance")

endmodule

`default_nettype wire

### hdl/xcfp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module xcfp_out_reg
	import xcfp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         res_valid,
	input  wire xcfp_result_t res,
	output      logic         in_ready,
	output      logic         out_valid,
	input  wire logic         out_ready,
	output      xcfp_result_t out_res
);

	logic         vld_q;
	xcfp_result_t res_q;

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_valid) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

`include "xor_checked_frame_parser_assert.svh"

	`XCFP_ASSERT_IMP(a_empty_ready, clk, arst_n, !vld_q, in_ready, "empty result register not ready")
	`XCFP_ASSERT_NXT(a_stall_holds, clk, arst_n, vld_q && !out_ready, vld_q && res_q == $past(res_q), "stalled result lost or changed")

endmodule

`default_nettype wire

### hdl/xor_checked_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Transaction
// s_*        in         one frame byte, tlast on the checksum byte
// m_*        out        payload byte (tuser 0) or end-of-frame report (tuser 1)
// APB        in         header_first at 0x0, header_second at 0x4
//
// A byte can be accepted every cycle unless a result waits and m_tready is low.
// A result appears on m_* the cycle after its byte is accepted.
// The single result register sets the rate: s_tready drops only while a
// result waits and m_tready is low.
// arst_n clears frame state, header registers and the result valid flag.

module xor_checked_frame_parser
	import xcfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,  // rx_byte
	input  wire logic        s_tlast,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [79:0] m_tdata,  // payload_byte, payload_index, frame_status,
	                                   // command, subcommand, payload_length,
	                                   // return_code, zero pad
	output      logic        m_tuser,  // report_kind
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	logic [7:0]   hdr_first_q;
	logic [7:0]   hdr_second_q;
	logic         take;
	logic         res_valid;
	xcfp_result_t res;
	xcfp_result_t out_res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q  <= '0;
			hdr_second_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_HDR_FIRST:  hdr_first_q  <= pwdata[7:0];
				REG_HDR_SECOND: hdr_second_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HDR_FIRST:  prdata = {24'd0, hdr_first_q};
			REG_HDR_SECOND: prdata = {24'd0, hdr_second_q};
			default:        prdata = '0;
		endcase
	end

	assign take = s_tvalid && s_tready;

	xcfp_frame_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.hdr_first  (hdr_first_q),
		.hdr_second (hdr_second_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	xcfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tuser = out_res.report_kind;
	assign m_tdata = {5'd0, out_res.return_code, out_res.payload_length, out_res.subcommand,
		out_res.command, out_res.frame_status, out_res.payload_index, out_res.payload_byte};

endmodule

`default_nettype wire

### tb/tb_xor_checked_frame_parser.sv
`timescale 1ns / 1ps

module tb_xor_checked_frame_parser;
	import xcfp_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_BYTES = 145;
	localparam int HOLD_CYCLES = 150;

	typedef struct {
		logic [7:0]   data;
		logic         last;
		logic         pinned;
		xcfp_result_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [7:0]       cfg_hdr1;
	logic [7:0]       cfg_hdr2;
	logic [POS_W-1:0] pos;
	logic [7:0]       xsum;
	logic             hdr_bad;
	logic [7:0]       cap_cmd;
	logic [7:0]       cap_sub;
	logic [15:0]      cap_len;
	logic [7:0]       code_hi;
	logic [7:0]       code_lo;

	xcfp_result_t pending_results[$];
	dir_row_t     dir_table[$];
	logic         pin_on;
	xcfp_result_t pin_res;
	logic         calm;
	logic         hold_req;
	int           failures;
	int           cycle_count;
	logic         made_one;
	xcfp_result_t next_res;
	xcfp_result_t want_res;
	xcfp_result_t seen_res;

	xor_checked_frame_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_frame_state();
		pos     = '0;
		xsum    = '0;
		hdr_bad = 1'b0;
		cap_cmd = '0;
		cap_sub = '0;
		cap_len = '0;
		code_hi = '0;
		code_lo = '0;
	endfunction

	function automatic void frame_track(input logic [7:0] b, input logic last,
			output logic made, output xcfp_result_t r);
		int unsigned p;
		int unsigned n;
		p = pos;
		n = cap_len;
		made = 1'b0;
		r = '0;
		if (last) begin
			made = 1'b1;
			r.report_kind = REPORT_FRAME;
			if (p + 1 < MIN_FRAME_LEN)
				r.frame_status = ST_SHORT;
			else if (hdr_bad)
				r.frame_status = ST_BAD_HDR;
			else if (p < n + 8)
				r.frame_status = ST_TRUNCATED;
			else if (xsum != b)
				r.frame_status = ST_BAD_SUM;
			else
				r.frame_status = ST_OK;
			r.command        = cap_cmd;
			r.subcommand     = cap_sub;
			r.payload_length = cap_len;
			r.return_code    = {code_hi, code_lo};
			clear_frame_state();
			return;
		end
		if (p == 0) begin
			if (b != cfg_hdr1) hdr_bad = 1'b1;
		end else if (p == 1) begin
			if (b != cfg_hdr2) hdr_bad = 1'b1;
		end else if (p == 2) begin
			cap_cmd = b;
		end else if (p == 3) begin
			cap_sub = b;
		end else if (p == 4) begin
			cap_len[7:0] = b;
		end else if (p == 5) begin
			cap_len[15:8] = b;
		end else if (p < 6 + n) begin
			made = 1'b1;
			r.report_kind   = REPORT_PAYLOAD;
			r.payload_byte  = b;
			r.payload_index = 16'(p - 6);
		end else if (p == 6 + n) begin
			code_hi = b;
		end else if (p == 7 + n) begin
			code_lo = b;
		end
		xsum = xsum ^ b;
		if (pos != POS_MAX) pos = pos + 1'b1;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
			failures++;
		end
	endfunction

	function automatic xcfp_result_t frame_rpt(logic [2:0] st, logic [7:0] cmd, logic [7:0] sub,
			logic [15:0] len, logic [15:0] code);
		xcfp_result_t r;
		r = '0;
		r.report_kind    = REPORT_FRAME;
		r.frame_status   = st;
		r.command        = cmd;
		r.subcommand     = sub;
		r.payload_length = len;
		r.return_code    = code;
		return r;
	endfunction

	function automatic dir_row_t plain(logic [7:0] b);
		dir_row_t d;
		d.data   = b;
		d.last   = 1'b0;
		d.pinned = 1'b0;
		d.want   = '0;
		return d;
	endfunction

	function automatic dir_row_t closing(logic [7:0] b, xcfp_result_t want);
		dir_row_t d;
		d.data   = b;
		d.last   = 1'b1;
		d.pinned = 1'b1;
		d.want   = want;
		return d;
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t unexpected output transaction: expected none, actual tdata=%h tuser=%b",
						$time, m_tdata, m_tuser);
					failures++;
				end else begin
					want_res = pending_results.pop_front();
					seen_res = xcfp_result_t'({m_tdata[74:0], m_tuser});
					check_field("report_kind", want_res.report_kind, seen_res.report_kind);
					check_field("payload_byte", want_res.payload_byte, seen_res.payload_byte);
					check_field("payload_index", want_res.payload_index, seen_res.payload_index);
					check_field("frame_status", want_res.frame_status, seen_res.frame_status);
					check_field("command", want_res.command, seen_res.command);
					check_field("subcommand", want_res.subcommand, seen_res.subcommand);
					check_field("payload_length", want_res.payload_length,
						seen_res.payload_length);
					check_field("return_code", want_res.return_code, seen_res.return_code);
					check_field("tdata pad", 16'd0, m_tdata[79:75]);
				end
			end
			if (s_tvalid && s_tready) begin
				frame_track(s_tdata, s_tlast, made_one, next_res);
				if (made_one) begin
					if (pin_on) next_res = pin_res;
					pending_results.push_back(next_res);
				end
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (calm) begin
				m_tready = 1'b1;
				@(negedge clk);
			end else if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready = ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tlast  = last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_header(input logic idx, input logic [7:0] v);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {24'd0, v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_HDR_FIRST)
			cfg_hdr1 = v;
		else
			cfg_hdr2 = v;
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'd0, v}) begin
			$display("%0t register readback mismatch at %h: expected %h, actual %h",
				$time, paddr, {24'd0, v}, prdata);
			failures++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic send_random_frame(output int sent);
		logic [7:0]  body[$];
		logic [7:0]  sum;
		logic [15:0] len;
		int          sel;
		int          cut;
		body = {};
		sel = $urandom_range(0, 99);
		if (sel < 6) begin
			repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
		end else begin
			body.push_back(sel < 14 ? 8'($urandom) : cfg_hdr1);
			body.push_back((sel >= 14 && sel < 20) ? 8'($urandom) : cfg_hdr2);
			body.push_back(8'($urandom));
			body.push_back(8'($urandom));
			if (sel < 28)
				len = 16'($urandom);
			else if (sel < 40)
				len = 16'($urandom_range(7, 40));
			else
				len = 16'($urandom_range(0, 6));
			body.push_back(len[7:0]);
			body.push_back(len[15:8]);
			if (len > 40) begin
				repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
			end else begin
				repeat (len) body.push_back(8'($urandom));
				body.push_back(8'($urandom));
				body.push_back(8'($urandom));
				if (sel >= 90) repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
				if (sel >= 80 && sel < 90) begin
					cut = $urandom_range(2, body.size() - 1);
					while (body.size() > cut) void'(body.pop_back());
				end
			end
		end
		sum = '0;
		foreach (body[i]) sum = sum ^ body[i];
		if (sel >= 70 && sel < 80) sum = sum ^ 8'(1 << $urandom_range(0, 7));
		foreach (body[i]) send_byte(body[i], 1'b0);
		send_byte(sum, 1'b1);
		sent = body.size() + 1;
	endtask

	initial begin
		logic [7:0] hdr_a[4];
		logic [7:0] hdr_b[4];
		int         phase_bytes;
		int         n;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		pin_on      = 1'b0;
		pin_res     = '0;
		calm        = 1'b0;
		hold_req    = 1'b0;
		failures    = 0;
		cycle_count = 0;
		cfg_hdr1    = '0;
		cfg_hdr2    = '0;
		clear_frame_state();
		hdr_a = '{8'hFF, 8'h00, 8'($urandom), 8'hA5};
		hdr_b = '{8'hFF, 8'h00, 8'($urandom), 8'h5A};

		dir_table = {
			plain(8'hFF),
			closing(8'h00, frame_rpt(ST_SHORT, 8'h00, 8'h00, 16'h0000, 16'h0000)),
			plain(8'h00), plain(8'h00), plain(8'hFF), plain(8'h00), plain(8'h01), plain(8'h00),
			plain(8'hFF), plain(8'h80), plain(8'h7F),
			closing(8'hFE, frame_rpt(ST_OK, 8'hFF, 8'h00, 16'h0001, 16'h807F)),
			plain(8'h7F), plain(8'h00), plain(8'h01), plain(8'h02), plain(8'h00), plain(8'h00),
			plain(8'h12), plain(8'h34),
			closing(8'h24, frame_rpt(ST_BAD_HDR, 8'h01, 8'h02, 16'h0000, 16'h1234)),
			plain(8'h00), plain(8'h00), plain(8'h12), plain(8'h34), plain(8'h00),
			closing(8'h00, frame_rpt(ST_TRUNCATED, 8'h12, 8'h34, 16'h0000, 16'h0000))
		};

		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_table[i]) begin
			pin_on  = dir_table[i].pinned;
			pin_res = dir_table[i].want;
			send_byte(dir_table[i].data, dir_table[i].last);
		end
		pin_on = 1'b0;

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			set_header(REG_HDR_FIRST, hdr_a[ph]);
			set_header(REG_HDR_SECOND, hdr_b[ph]);
			if (ph == 1) hold_req = 1'b1;
			if (ph == 3) calm = 1'b1;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				send_random_frame(n);
				phase_bytes += n;
			end
		end
		drain();
		repeat (10) @(negedge clk);

		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/xcfp_pkg.sv
hdl/xcfp_frame_track.sv
hdl/xcfp_out_reg.sv
hdl/xor_checked_frame_parser.sv
tb/tb_xor_checked_frame_parser.sv
